// ===== hw/rtl/dfa_iso_pkg.sv =====
// Package for the DFA isomorphism checker: sizes, codes, FSM states and the
// command/status structs shared by controller and datapath.
// No dependencies.
package dfa_iso_pkg;

  localparam int MAX_STATES  = 64;
  localparam int ALPHABET    = 32;
  localparam int STATE_W     = $clog2(MAX_STATES);
  localparam int SYM_W       = $clog2(ALPHABET);
  localparam int SYMC_W      = $clog2(ALPHABET + 1);
  localparam int TRANS_DEPTH = MAX_STATES * ALPHABET;
  localparam int TRANS_AW    = STATE_W + SYM_W;

  // fixed field widths of the ports
  localparam int IN_STATE_W = 6;
  localparam int IN_SYM_W   = 5;
  localparam int CFG_W      = 6;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_START = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATES_A    = 2'd0,
    CFG_STATES_B    = 2'd1,
    CFG_TERMINALS_A = 2'd2,
    CFG_TERMINALS_B = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_EVAL,
    ST_MAP,
    ST_POP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [STATE_W-1:0] u;
    logic [STATE_W-1:0] v;
    logic [SYMC_W-1:0]  sym;
  } frame_t;

  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic load_wr;
    logic mark_wr;
    logic walk_init;
    logic fetch;
    logic pop;
    logic enter;
    logic map_rd;
    logic restore;
    logic finish;
    logic result;
  } dfa_iso_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic counts_ok;
    logic root_ok;
    logic sym_end;
    logic sp_empty;
    logic t_both_zero;
    logic t_one_zero;
    logic t1_visited;
    logic enter_ok;
    logic map_ok;
    logic out_busy;
  } dfa_iso_sts_t;

endpackage

// ===== hw/rtl/dfa_iso_ctrl.sv =====
// Controller FSM of the DFA isomorphism checker: table clearing sweep,
// item dispatch and the depth-first walk sequence. Uses dfa_iso_pkg.
module dfa_iso_ctrl
  import dfa_iso_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic [1:0]   in_func,
  input  dfa_iso_sts_t sts,
  output logic         in_stall,
  output dfa_iso_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   result_r, result_nxt;
  func_t  func;

  assign func = func_t'(in_func);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      result_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      result_r <= result_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    result_nxt = result_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_CLEAR: state_nxt = ST_CLEAR;
            FUNC_START: begin
              if (sts.counts_ok && sts.root_ok) begin
                state_nxt = ST_FETCH;
              end else begin
                state_nxt  = ST_DONE;
                result_nxt = 1'b0;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_FETCH: begin
        if (!sts.sym_end) begin
          state_nxt = ST_EVAL;
        end else if (sts.sp_empty) begin
          state_nxt  = ST_DONE;
          result_nxt = 1'b1;
        end else begin
          state_nxt = ST_POP;
        end
      end
      ST_EVAL: begin
        if (sts.t_both_zero) begin
          state_nxt = ST_FETCH;
        end else if (sts.t_one_zero) begin
          state_nxt  = ST_DONE;
          result_nxt = 1'b0;
        end else if (sts.t1_visited) begin
          state_nxt = ST_MAP;
        end else if (sts.enter_ok) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt  = ST_DONE;
          result_nxt = 1'b0;
        end
      end
      ST_MAP: begin
        if (sts.map_ok) begin
          state_nxt = ST_FETCH;
        end else begin
          state_nxt  = ST_DONE;
          result_nxt = 1'b0;
        end
      end
      ST_POP:  state_nxt = ST_FETCH;
      ST_DONE: begin
        if (!sts.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_stall = (state_r != ST_IDLE);
    cmd.result = result_r;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        if (in_valid) begin
          case (func)
            FUNC_LOAD:  cmd.load_wr   = 1'b1;
            FUNC_MARK:  cmd.mark_wr   = 1'b1;
            FUNC_START: cmd.walk_init = 1'b1;
            FUNC_CLEAR: cmd.clr_init  = 1'b1;
            default:    cmd.load_wr   = 1'b0;
          endcase
        end
      end
      ST_FETCH: begin
        cmd.fetch = !sts.sym_end;
        cmd.pop   = sts.sym_end && !sts.sp_empty;
      end
      ST_EVAL: begin
        cmd.map_rd = !sts.t_both_zero && !sts.t_one_zero && sts.t1_visited;
        cmd.enter  = !sts.t_both_zero && !sts.t_one_zero && !sts.t1_visited &&
                     sts.enter_ok;
      end
      ST_POP:  cmd.restore = 1'b1;
      ST_DONE: cmd.finish  = !sts.out_busy;
      default: cmd.result  = result_r;
    endcase
  end

  a_start_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && func == FUNC_START) |=> in_stall)
    else $error("start transaction did not hold off the input");

  a_pop_then_restore: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POP) |-> $past(cmd.pop))
    else $error("restore without a preceding stack read");

endmodule

// ===== hw/rtl/dfa_iso_dp.sv =====
// Datapath of the DFA isomorphism checker: configuration registers,
// transition memories, terminal and visited bits, pairing map, walk stack
// and the result register. Uses dfa_iso_pkg.
module dfa_iso_dp
  import dfa_iso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dfa_iso_cmd_t          cmd,
  output dfa_iso_sts_t          sts,
  input  logic                  in_which,
  input  logic [IN_STATE_W-1:0] in_state_index,
  input  logic [IN_SYM_W-1:0]   in_symbol,
  input  logic [IN_STATE_W-1:0] in_target,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  out_stall,
  output logic                  out_valid,
  output logic                  out_isomorphic
);

  logic [CFG_W-1:0] states_a_r, states_b_r, terminals_a_r, terminals_b_r;

  logic [STATE_W-1:0] trans_a_mem [TRANS_DEPTH];
  logic [STATE_W-1:0] trans_b_mem [TRANS_DEPTH];
  logic [STATE_W-1:0] map_mem     [MAX_STATES];
  frame_t             stack_mem   [MAX_STATES];

  logic [TRANS_AW-1:0]   clr_addr_r;
  logic [MAX_STATES-1:0] term_a_r, term_b_r, visited_r;
  logic [STATE_W-1:0]    cu_r, cv_r, sp_r;
  logic [SYMC_W-1:0]     csym_r;
  logic [STATE_W-1:0]    ta_q, tb_q, map_q;
  frame_t                stack_q;
  logic                  out_valid_r, out_iso_r;

  logic                load_ok, mark_ok;
  logic [STATE_W-1:0]  in_s, in_t;
  logic [SYM_W-1:0]    in_c;
  logic                ta_we, tb_we;
  logic [TRANS_AW-1:0] t_waddr;
  logic [STATE_W-1:0]  t_wdata;
  logic [TRANS_AW-1:0] ra_addr, rb_addr;

  assign in_s    = STATE_W'(in_state_index);
  assign in_t    = STATE_W'(in_target);
  assign in_c    = SYM_W'(in_symbol);
  assign load_ok = (32'(in_state_index) < MAX_STATES) && (32'(in_symbol) < ALPHABET) &&
                   (32'(in_target) < MAX_STATES);
  assign mark_ok = (32'(in_state_index) < MAX_STATES);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      states_a_r    <= CFG_W'(1);
      states_b_r    <= CFG_W'(1);
      terminals_a_r <= '0;
      terminals_b_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STATES_A:    states_a_r    <= cfg_data;
        CFG_STATES_B:    states_b_r    <= cfg_data;
        CFG_TERMINALS_A: terminals_a_r <= cfg_data;
        CFG_TERMINALS_B: terminals_b_r <= cfg_data;
        default:         states_a_r    <= states_a_r;
      endcase
    end
  end

  // clear sweep counter and terminal bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      term_a_r   <= '0;
      term_b_r   <= '0;
    end else begin
      if (cmd.clr_init) begin
        clr_addr_r <= '0;
        term_a_r   <= '0;
        term_b_r   <= '0;
      end else if (cmd.clr_step) begin
        clr_addr_r <= clr_addr_r + TRANS_AW'(1);
      end
      if (cmd.mark_wr && mark_ok) begin
        if (in_which) term_b_r[in_s] <= 1'b1;
        else          term_a_r[in_s] <= 1'b1;
      end
    end
  end

  // transition table write port: sweep zeroes, else load
  always_comb begin
    ta_we   = 1'b0;
    tb_we   = 1'b0;
    t_waddr = clr_addr_r;
    t_wdata = '0;
    if (cmd.clr_step) begin
      ta_we = 1'b1;
      tb_we = 1'b1;
    end else if (cmd.load_wr && load_ok) begin
      ta_we   = !in_which;
      tb_we   = in_which;
      t_waddr = {in_s, in_c};
      t_wdata = in_t;
    end
  end

  assign ra_addr = {cu_r, csym_r[SYM_W-1:0]};
  assign rb_addr = {cv_r, csym_r[SYM_W-1:0]};

  always_ff @(posedge clk) begin
    if (ta_we) trans_a_mem[t_waddr] <= t_wdata;
    if (cmd.fetch) ta_q <= trans_a_mem[ra_addr];
  end

  always_ff @(posedge clk) begin
    if (tb_we) trans_b_mem[t_waddr] <= t_wdata;
    if (cmd.fetch) tb_q <= trans_b_mem[rb_addr];
  end

  // pairing map
  always_ff @(posedge clk) begin
    if (cmd.walk_init) map_mem[STATE_W'(1)] <= STATE_W'(1);
    else if (cmd.enter) map_mem[ta_q] <= tb_q;
    if (cmd.map_rd) map_q <= map_mem[ta_q];
  end

  // walk stack holds suspended parent frames
  always_ff @(posedge clk) begin
    if (cmd.enter) stack_mem[sp_r] <= '{u: cu_r, v: cv_r, sym: csym_r};
    if (cmd.pop) stack_q <= stack_mem[sp_r - STATE_W'(1)];
  end

  // current frame, stack pointer, visited bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r      <= '0;
      visited_r <= '0;
    end else if (cmd.walk_init) begin
      sp_r      <= '0;
      visited_r <= MAX_STATES'(2);
    end else if (cmd.enter) begin
      sp_r            <= sp_r + STATE_W'(1);
      visited_r[ta_q] <= 1'b1;
    end else if (cmd.pop) begin
      sp_r <= sp_r - STATE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      cu_r   <= STATE_W'(1);
      cv_r   <= STATE_W'(1);
      csym_r <= '0;
    end else if (cmd.enter) begin
      cu_r   <= ta_q;
      cv_r   <= tb_q;
      csym_r <= '0;
    end else if (cmd.restore) begin
      cu_r   <= stack_q.u;
      cv_r   <= stack_q.v;
      csym_r <= stack_q.sym;
    end else if (cmd.fetch) begin
      csym_r <= csym_r + SYMC_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_iso_r <= cmd.result;
  end

  assign out_valid      = out_valid_r;
  assign out_isomorphic = out_iso_r;

  always_comb begin
    sts.clr_last    = (clr_addr_r == TRANS_AW'(TRANS_DEPTH - 1));
    sts.counts_ok   = (states_a_r == states_b_r) && (terminals_a_r == terminals_b_r);
    sts.root_ok     = (term_a_r[STATE_W'(1)] == term_b_r[STATE_W'(1)]);
    sts.sym_end     = (csym_r == SYMC_W'(ALPHABET));
    sts.sp_empty    = (sp_r == '0);
    sts.t_both_zero = (ta_q == '0) && (tb_q == '0);
    sts.t_one_zero  = (ta_q == '0) != (tb_q == '0);
    sts.t1_visited  = visited_r[ta_q];
    sts.enter_ok    = (term_a_r[ta_q] == term_b_r[tb_q]) &&
                      (sp_r != STATE_W'(MAX_STATES - 1));
    sts.map_ok      = (map_q == tb_q);
    sts.out_busy    = out_valid_r;
  end

  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r)
    else $error("result loaded over a pending result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (sp_r != '0))
    else $error("walk stack underflow");

  a_enter_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enter |-> !visited_r[ta_q])
    else $error("state of first automaton entered twice");

endmodule

// ===== hw/rtl/dfa_isomorphism_checker_core.sv =====
// Top level of the DFA isomorphism checker.
// Instantiates dfa_iso_ctrl and dfa_iso_dp; uses dfa_iso_pkg.
//
// Holds two deterministic automata of up to 64 states over 32 symbols and
// checks them for isomorphism by a depth-first pairing walk from state 1 of
// each. Input transactions: func 0 loads one transition slot (target 0 means
// none), func 1 marks a state terminal, func 2 starts a check and returns one
// transaction on isomorphic, func 3 clears both transition and terminal
// tables. Load and mark transactions are taken one per cycle while the block
// is idle. After reset and after every clear transaction the transition
// memories are swept to zero, one address of both tables per cycle, while
// in_stall is high (configuration writes still land). A start transaction
// holds off the input until its result enters the output register: when the
// counts or state 1 terminal marks differ, it goes straight to done; else each
// symbol examined on each visited pair takes a memory read and an evaluation,
// plus a map check where the target was already mapped, and each return to a
// parent pair a stack read and restore. The pace is set by the single read
// port of each transition memory. The result waits in an output register, so
// load and mark transactions keep flowing while it is stalled. Configure
// states_a/b and terminals_a/b (indices 0..3) only while the block is idle.
module dfa_isomorphism_checker_core
  import dfa_iso_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input transactions
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_func,
  input  logic                  in_which,
  input  logic [IN_STATE_W-1:0] in_state_index,
  input  logic [IN_SYM_W-1:0]   in_symbol,
  input  logic [IN_STATE_W-1:0] in_target,
  // result transactions
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_isomorphic,
  // configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  dfa_iso_cmd_t cmd;
  dfa_iso_sts_t sts;

  // sequencing: clear sweep, dispatch, walk steps
  dfa_iso_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // tables, walk state and result register
  dfa_iso_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_which       (in_which),
    .in_state_index (in_state_index),
    .in_symbol      (in_symbol),
    .in_target      (in_target),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_isomorphic (out_isomorphic)
  );

endmodule

// ===== tb/sv/dfa_isomorphism_checker_core_tb.sv =====
// Self-checking testbench for dfa_isomorphism_checker_core: builds automaton pairs,
// runs isomorphism checks and compares every result against a local walk predictor.
// Depends on dfa_iso_pkg and the RTL of the core.
`timescale 1ns / 1ps

module dfa_isomorphism_checker_core_tb
  import dfa_iso_pkg::*;
();

  // Leave a wide margin over the worst correct run.
  localparam int CYCLE_LIMIT   = 4_000_000;
  // A clear transaction sweeps every transition slot; let that finish before
  // touching the count registers.
  localparam int SETTLE_CYCLES = TRANS_DEPTH + 32;
  localparam int DRAIN_CYCLES  = 64;

  typedef struct {
    func_t                 f;
    bit                    w;
    logic [IN_STATE_W-1:0] s;
    logic [IN_SYM_W-1:0]   c;
    logic [IN_STATE_W-1:0] t;
  } table_op_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_func;
  logic                  in_which;
  logic [IN_STATE_W-1:0] in_state_index;
  logic [IN_SYM_W-1:0]   in_symbol;
  logic [IN_STATE_W-1:0] in_target;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_isomorphic;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // Predictor copy of the block: tables, terminal marks and count registers.
  logic [STATE_W-1:0] a_next [TRANS_DEPTH];
  logic [STATE_W-1:0] b_next [TRANS_DEPTH];
  bit                 a_final [MAX_STATES];
  bit                 b_final [MAX_STATES];
  logic [CFG_W-1:0]   n_states_a, n_states_b, n_term_a, n_term_b;

  bit iso_expected [$];   // verdicts of accepted start transactions, oldest first
  int items_sent;
  int verdicts_seen = 0;
  int mismatches    = 0;
  int cycle_count   = 0;
  bit sender_idles;
  bit receiver_idles;

  dfa_isomorphism_checker_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_which       (in_which),
    .in_state_index (in_state_index),
    .in_symbol      (in_symbol),
    .in_target      (in_target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_isomorphic (out_isomorphic),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake or a runaway walk ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_tables();
    foreach (a_next[i]) begin
      a_next[i] = '0;
      b_next[i] = '0;
    end
    foreach (a_final[i]) begin
      a_final[i] = 1'b0;
      b_final[i] = 1'b0;
    end
  endfunction

  // Depth-first pairing walk from state 1 of both automata. Each frame holds
  // the pair and the next symbol to try; a state of A enters at most once.
  function automatic bit predict_isomorphic();
    bit                 seen    [MAX_STATES];
    logic [STATE_W-1:0] partner [MAX_STATES];
    logic [STATE_W-1:0] fu      [MAX_STATES];
    logic [STATE_W-1:0] fv      [MAX_STATES];
    int                 fs      [MAX_STATES];
    int                 depth;
    int                 c;
    logic [STATE_W-1:0] ta, tb;
    if (n_states_a != n_states_b || n_term_a != n_term_b) return 1'b0;
    foreach (seen[i]) seen[i] = 1'b0;
    seen[1] = 1'b1;
    if (a_final[1] != b_final[1]) return 1'b0;
    partner[1] = 1;
    fu[0] = 1;
    fv[0] = 1;
    fs[0] = 0;
    depth = 1;
    while (depth > 0) begin
      if (fs[depth-1] >= ALPHABET) begin
        depth--;
        continue;
      end
      c = fs[depth-1];
      fs[depth-1]++;
      ta = a_next[fu[depth-1] * ALPHABET + c];
      tb = b_next[fv[depth-1] * ALPHABET + c];
      if (ta == 0 && tb == 0) continue;
      if (ta == 0 || tb == 0) return 1'b0;
      if (seen[ta]) begin
        if (partner[ta] != tb) return 1'b0;
      end else begin
        seen[ta] = 1'b1;
        if (a_final[ta] != b_final[tb]) return 1'b0;
        partner[ta] = tb;
        if (depth >= MAX_STATES) return 1'b0;
        fu[depth] = ta;
        fv[depth] = tb;
        fs[depth] = 0;
        depth++;
      end
    end
    return 1'b1;
  endfunction

  // Advance the predictor by one accepted input transaction.
  function automatic void apply_item(func_t f, bit w, logic [IN_STATE_W-1:0] s,
                                     logic [IN_SYM_W-1:0] c, logic [IN_STATE_W-1:0] t);
    case (f)
      FUNC_LOAD: begin
        if (w) b_next[s * ALPHABET + c] = t;
        else   a_next[s * ALPHABET + c] = t;
      end
      FUNC_MARK: begin
        if (w) b_final[s] = 1'b1;
        else   a_final[s] = 1'b1;
      end
      FUNC_START: iso_expected.insert(iso_expected.size(), predict_isomorphic());
      default:    clear_tables();
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Drive one input transaction at a falling edge, hold it until a rising edge
  // sees in_stall low, then advance the predictor. An optional gap drops valid
  // first; valid otherwise stays high straight into the next transaction.
  task automatic send_item(func_t f, bit w, logic [IN_STATE_W-1:0] s,
                           logic [IN_SYM_W-1:0] c, logic [IN_STATE_W-1:0] t);
    int gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_func        <= f;
    in_which       <= w;
    in_state_index <= s;
    in_symbol      <= c;
    in_target      <= t;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
    apply_item(f, w, s, c, t);
  endtask

  // Drop valid and hold off until every verdict has come back, then let any
  // clear sweep run out so the block is truly idle.
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (iso_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STATES_A:    n_states_a = val;
      CFG_STATES_B:    n_states_b = val;
      CFG_TERMINALS_A: n_term_a   = val;
      default:         n_term_b   = val;
    endcase
  endtask

  task automatic set_counts(logic [CFG_W-1:0] sa, logic [CFG_W-1:0] sb,
                            logic [CFG_W-1:0] ta, logic [CFG_W-1:0] tb);
    wait_idle();
    write_reg(CFG_STATES_A, sa);
    write_reg(CFG_STATES_B, sb);
    write_reg(CFG_TERMINALS_A, ta);
    write_reg(CFG_TERMINALS_B, tb);
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic got, logic want);
    mismatches++;
    if (mismatches <= 50)
      $display("mismatch at result %0d: %s (got %b, want %b)",
               verdicts_seen, what, got, want);
  endtask

  // Stall the result channel in random bursts, with open runs between them;
  // hold it open whenever receiver idling is off.
  initial begin : result_stalls
    int hold;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (receiver_idles && $urandom_range(0, 1) == 1) begin
        out_stall <= 1'b1;
        hold = $urandom_range(0, 16);
      end else begin
        out_stall <= 1'b0;
        hold = $urandom_range(0, 40);
      end
    end
  end

  // Compare each accepted verdict with the oldest pending prediction.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (iso_expected.size() == 0) begin
        report_mismatch("verdict with no start pending", out_isomorphic, 1'bx);
      end else begin
        if (out_isomorphic !== iso_expected[0])
          report_mismatch("isomorphic", out_isomorphic, iso_expected[0]);
        void'(iso_expected.pop_front());
      end
      verdicts_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Empty tables after reset: both roots non-terminal, nothing to walk.
  task automatic test_empty_tables();
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
  endtask

  // Highest state, symbol and target on both sides, plus a load out of state 0
  // that the walk can never reach.
  task automatic test_field_extremes();
    send_item(FUNC_LOAD, 1'b0, 6'd1, 5'd0, 6'd63);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd0, 6'd63);
    send_item(FUNC_LOAD, 1'b0, 6'd63, 5'd31, 6'd1);
    send_item(FUNC_LOAD, 1'b1, 6'd63, 5'd31, 6'd1);
    send_item(FUNC_MARK, 1'b0, 6'd63, 5'd31, 6'd63);
    send_item(FUNC_MARK, 1'b1, 6'd63, 5'd0, 6'd0);
    send_item(FUNC_LOAD, 1'b0, 6'd0, 5'd7, 6'd3);
    send_item(FUNC_START, 1'b1, 6'd63, 5'd31, 6'd63);
  endtask

  // Transition on one side only, then withdrawn by loading target none.
  task automatic test_one_sided_edge();
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd31, 6'd5);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd31, 6'd0);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
  endtask

  // Two symbols reach the same state of A but different states of B; then
  // overwrite the slot so the partners agree.
  task automatic test_partner_conflict();
    send_item(FUNC_LOAD, 1'b0, 6'd1, 5'd3, 6'd2);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd3, 6'd3);
    send_item(FUNC_LOAD, 1'b0, 6'd1, 5'd4, 6'd2);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd4, 6'd4);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd4, 6'd3);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
  endtask

  // Root terminal on one side, then both; a clear addressed to B wipes both.
  task automatic test_terminal_marks();
    send_item(FUNC_MARK, 1'b0, 6'd1, 5'd0, 6'd0);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    send_item(FUNC_MARK, 1'b1, 6'd1, 5'd0, 6'd0);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    send_item(FUNC_CLEAR, 1'b1, 6'd0, 5'd0, 6'd0);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
  endtask

  // Count registers: differing state counts, differing terminal counts, and
  // zero state counts where the walk still starts at state 1.
  task automatic test_count_checks();
    set_counts(6'd5, 6'd6, 6'd0, 6'd0);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    set_counts(6'd6, 6'd6, 6'd0, 6'd63);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    set_counts(6'd0, 6'd0, 6'd63, 6'd63);
    send_item(FUNC_LOAD, 1'b0, 6'd1, 5'd2, 6'd1);
    send_item(FUNC_LOAD, 1'b1, 6'd1, 5'd2, 6'd1);
    send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Random tests
  // ---------------------------------------------------------------------------

  function automatic table_op_t pack_op(func_t f, bit w, logic [IN_STATE_W-1:0] s,
                                        logic [IN_SYM_W-1:0] c,
                                        logic [IN_STATE_W-1:0] t);
    table_op_t op;
    op.f = f;
    op.w = w;
    op.s = s;
    op.c = c;
    op.t = t;
    return op;
  endfunction

  // Fully random transactions; clears kept rare since each one sweeps.
  task automatic send_noise(int count);
    func_t f;
    repeat (count) begin
      f = func_t'($urandom_range(0, 2));
      if ($urandom_range(0, 15) == 0) f = FUNC_CLEAR;
      send_item(f, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    end
  endtask

  // Build automaton A over random labels and B as a relabeled copy, load both
  // in shuffled order, maybe break the copy in one place, then check.
  task automatic run_walk_case();
    table_op_t          plan [$];
    table_op_t          tmp;
    logic [STATE_W-1:0] lab_a [20];
    logic [STATE_W-1:0] lab_b [20];
    bit                 taken_a [MAX_STATES];
    bit                 taken_b [MAX_STATES];
    logic [IN_SYM_W-1:0] syms [4];
    int                 n, k, j, dst;
    foreach (taken_a[i]) begin
      taken_a[i] = 1'b0;
      taken_b[i] = 1'b0;
    end
    if ($urandom_range(0, 2) != 0)
      send_item(FUNC_CLEAR, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
    lab_a[0] = 1;
    lab_b[0] = 1;
    for (int i = 1; i < n; i++) begin
      do lab_a[i] = 6'($urandom_range(2, 63)); while (taken_a[lab_a[i]]);
      taken_a[lab_a[i]] = 1'b1;
      do lab_b[i] = 6'($urandom_range(2, 63)); while (taken_b[lab_b[i]]);
      taken_b[lab_b[i]] = 1'b1;
    end
    k = $urandom_range(1, 4);
    for (int i = 0; i < k; i++) syms[i] = 5'($urandom_range(0, 31));
    for (int i = 0; i < n; i++) begin
      for (int c = 0; c < k; c++) begin
        if ($urandom_range(0, 3) != 0) begin
          dst = $urandom_range(0, n - 1);
          plan.insert(plan.size(),
                      pack_op(FUNC_LOAD, 1'b0, lab_a[i], syms[c], lab_a[dst]));
          plan.insert(plan.size(),
                      pack_op(FUNC_LOAD, 1'b1, lab_b[i], syms[c], lab_b[dst]));
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        plan.insert(plan.size(),
                    pack_op(FUNC_MARK, 1'b0, lab_a[i], 5'($urandom_range(0, 31)), 6'd0));
        plan.insert(plan.size(),
                    pack_op(FUNC_MARK, 1'b1, lab_b[i], 5'd0, 6'($urandom_range(0, 63))));
      end
    end
    for (int i = plan.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = plan[i];
      plan[i] = plan[j];
      plan[j] = tmp;
    end
    // Break the copy in one place about a third of the time.
    if ($urandom_range(0, 2) == 0) begin
      case ($urandom_range(0, 3))
        0: plan.insert(plan.size(),
                       pack_op(FUNC_LOAD, 1'b1, lab_b[$urandom_range(0, n - 1)],
                               syms[$urandom_range(0, k - 1)],
                               lab_b[$urandom_range(0, n - 1)]));
        1: plan.insert(plan.size(),
                       pack_op(FUNC_LOAD, 1'b1, lab_b[$urandom_range(0, n - 1)],
                               syms[$urandom_range(0, k - 1)], 6'd0));
        2: plan.insert(plan.size(),
                       pack_op(FUNC_MARK, 1'($urandom_range(0, 1)),
                               lab_a[$urandom_range(0, n - 1)], 5'd0, 6'd0));
        default: plan.insert(plan.size(),
                             pack_op(FUNC_LOAD, 1'b0, lab_a[$urandom_range(0, n - 1)],
                                     5'($urandom_range(0, 31)),
                                     lab_a[$urandom_range(0, n - 1)]));
      endcase
    end
    foreach (plan[i]) send_item(plan[i].f, plan[i].w, plan[i].s, plan[i].c, plan[i].t);
    send_item(FUNC_START, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
              5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    // Sometimes keep editing the same tables and check again.
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4))
        send_item(FUNC_LOAD, 1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                  syms[$urandom_range(0, k - 1)], 6'($urandom_range(0, 63)));
      send_item(FUNC_START, 1'b0, 6'd0, 5'd0, 6'd0);
    end
  endtask

  task automatic test_random_walks(int budget);
    int stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) send_noise($urandom_range(1, 6));
      run_walk_case();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_func        = FUNC_LOAD;
    in_which       = 1'b0;
    in_state_index = '0;
    in_symbol      = '0;
    in_target      = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_STATES_A;
    cfg_data       = '0;
    items_sent     = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    n_states_a     = 6'd1;
    n_states_b     = 6'd1;
    n_term_a       = 6'd0;
    n_term_b       = 6'd0;
    clear_tables();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part runs on the reset values of the count registers until test_count_checks sets them.
    test_empty_tables();
    test_field_extremes();
    test_one_sided_edge();
    test_partner_conflict();
    test_terminal_marks();
    test_count_checks();

    set_counts(6'd63, 6'd63, 6'd63, 6'd63);
    test_random_walks(300);
    set_counts(6'd7, 6'd7, 6'd2, 6'd2);
    test_random_walks(300);
    set_counts(6'd1, 6'd1, 6'd0, 6'd0);
    test_random_walks(300);
    set_counts(6'd0, 6'd0, 6'd0, 6'd0);
    test_random_walks(250);
    // Unequal state counts: every verdict must come back false.
    set_counts(6'd12, 6'd13, 6'd3, 6'd3);
    test_random_walks(100);
    // Last stretch at full rate on both sides.
    set_counts(6'd63, 6'd63, 6'd0, 6'd0);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    test_random_walks(300);

    @(negedge clk);
    in_valid <= 1'b0;
    while (iso_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
